### hdl/lbde_pkg.sv
// ----------------------------------------------------------------------------
// lbde_pkg
// Shared types, defaults and small arithmetic helpers for the luma
// difference-of-blurs edge block.
// ----------------------------------------------------------------------------
package lbde_pkg;

    localparam int LBDE_MAX_WIDTH  = 128;
    localparam int LBDE_MAX_HEIGHT = 128;
    localparam int LBDE_WINDOW     = 2;

    // register reset values
    localparam logic [7:0] RST_FRAME_WIDTH  = 8'd128;
    localparam logic [7:0] RST_FRAME_HEIGHT = 8'd128;
    localparam logic [7:0] RST_EDGE_THRESH  = 8'd5;
    localparam logic [7:0] RST_EDGE_VALUE   = 8'd240;
    localparam logic [2:0] RST_FINE_PASSES  = 3'd1;
    localparam logic [2:0] RST_COARSE_EXTRA = 3'd2;

    // register indexes
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_EDGE_THRESH  = 3'd2;
    localparam logic [2:0] REG_EDGE_VALUE   = 3'd3;
    localparam logic [2:0] REG_FINE_PASSES  = 3'd4;
    localparam logic [2:0] REG_COARSE_EXTRA = 3'd5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam int RECIP_SHIFT = 16;

    typedef struct packed {
        logic       command;
        logic [7:0] pixel;
    } t_in;

    typedef struct packed {
        logic [7:0] edge_res;
        logic       last_of_frame;
    } t_out;

    typedef struct packed {
        logic [7:0] frame_width;
        logic [7:0] frame_height;
        logic [7:0] edge_threshold;
        logic [7:0] edge_value;
        logic [2:0] fine_passes;
        logic [2:0] coarse_extra_passes;
    } t_cfg;

    // ceil(2^16 / d); exact floor of sum/d for sums below 2048
    function automatic logic [16:0] recip(input logic [3:0] d);
        logic [16:0] r;
        case (d)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] edge_pix(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] thr, input logic [7:0] val);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return (d > thr) ? val : 8'd0;
    endfunction

endpackage

### hdl/lbde_ram.sv
// ----------------------------------------------------------------------------
// lbde_ram
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbde_ram #(
    parameter  int DEPTH = lbde_pkg::LBDE_MAX_WIDTH * lbde_pkg::LBDE_MAX_HEIGHT,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

### hdl/lbde_seq.sv
// ----------------------------------------------------------------------------
// lbde_seq
// Frame processing sequencer: blur sweeps (read, then modify and write back),
// fine-to-coarse copy and the edge pass, all over the two frame stores.
// ----------------------------------------------------------------------------
module lbde_seq #(
    parameter  int MAX_WIDTH  = lbde_pkg::LBDE_MAX_WIDTH,
    parameter  int MAX_HEIGHT = lbde_pkg::LBDE_MAX_HEIGHT,
    parameter  int WINDOW     = lbde_pkg::LBDE_WINDOW,
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW         = $clog2(CELLS),
    localparam int CW         = $clog2(CELLS + 1),
    localparam int WDW        = $clog2(MAX_WIDTH + 1),
    localparam int HDW        = $clog2(MAX_HEIGHT + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [WDW-1:0] i_w,
    input  logic [HDW-1:0] i_h,
    input  logic [CW-1:0]  i_cells,
    input  lbde_pkg::t_cfg i_cfg,
    output logic           o_busy,
    output logic           o_done,
    output logic           o_f_we,
    output logic [AW-1:0]  o_f_waddr,
    output logic [7:0]     o_f_wdata,
    output logic [AW-1:0]  o_f_raddr,
    input  logic [7:0]     i_f_rdata,
    output logic           o_c_we,
    output logic [AW-1:0]  o_c_waddr,
    output logic [7:0]     o_c_wdata,
    output logic [AW-1:0]  o_c_raddr,
    input  logic [7:0]     i_c_rdata
);

    localparam int LW  = (WDW > HDW) ? WDW : HDW;
    localparam int NW  = $clog2(WINDOW + 1);
    localparam int SW  = 8 + NW;
    localparam int SLW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int PW  = SW + 17;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_BL_RD = 7'b0000010,
        S_BL_WR = 7'b0000100,
        S_CP    = 7'b0001000,
        S_CP_DR = 7'b0010000,
        S_ED    = 7'b0100000,
        S_ED_DR = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic            r_img;          // 0 fine store, 1 coarse store
    logic [2:0]      r_pass, r_passes;
    logic [1:0]      r_phase;        // rows fwd, rows back, cols down, cols up
    logic [LW-1:0]   r_line, r_k;
    logic [AW-1:0]   r_addr, r_row_base, r_last_base;
    logic [WDW-1:0]  r_w;
    logic [HDW-1:0]  r_h;
    logic [CW-1:0]   r_cells;
    logic [7:0]      r_win [WINDOW];
    logic [SLW-1:0]  r_slot;
    logic [SW-1:0]   r_sum;
    logic [NW-1:0]   r_cnt;
    logic [AW-1:0]   r_i;
    logic            r_pw, r_pe;
    logic [AW-1:0]   r_pwa;

    logic            blur_init, pass_next, pipe_init, img_coarse;
    logic [7:0]      v, old;
    logic [SW-1:0]   sum_n;
    logic [NW-1:0]   cnt_n;
    logic [PW-1:0]   prod;
    logic [LW-1:0]   len;
    logic            line_end, last_line;

    assign v        = r_img ? i_c_rdata : i_f_rdata;
    assign old      = r_win[r_slot];
    assign sum_n    = r_sum - SW'(old) + SW'(v);
    assign cnt_n    = r_cnt - NW'(old != 8'd0) + NW'(v != 8'd0);
    assign prod     = PW'(sum_n) * PW'(lbde_pkg::recip(4'(cnt_n)));
    assign len      = r_phase[1] ? LW'(r_h) : LW'(r_w);
    assign line_end = (r_state == S_BL_WR) && (r_k == len - LW'(1));
    assign last_line = (r_phase == 2'd3) && (r_line == LW'(r_w) - LW'(1));

    always_comb begin
        n_state    = r_state;
        blur_init  = 1'b0;
        pass_next  = 1'b0;
        pipe_init  = 1'b0;
        img_coarse = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cfg.fine_passes != 3'd0) begin
                        n_state   = S_BL_RD;
                        blur_init = 1'b1;
                    end else begin
                        n_state   = S_CP;
                        pipe_init = 1'b1;
                    end
                end
            end
            S_BL_RD: n_state = S_BL_WR;
            S_BL_WR: begin
                n_state = S_BL_RD;
                if (line_end && last_line) begin
                    if (r_pass == r_passes - 3'd1) begin
                        n_state   = r_img ? S_ED : S_CP;
                        pipe_init = 1'b1;
                    end else begin
                        pass_next = 1'b1;
                    end
                end
            end
            S_CP: begin
                if (CW'(r_i) == r_cells - CW'(1)) begin
                    n_state = S_CP_DR;
                end
            end
            S_CP_DR: begin
                img_coarse = 1'b1;
                if (i_cfg.coarse_extra_passes != 3'd0) begin
                    n_state   = S_BL_RD;
                    blur_init = 1'b1;
                end else begin
                    n_state   = S_ED;
                    pipe_init = 1'b1;
                end
            end
            S_ED: begin
                if (CW'(r_i) == r_cells - CW'(1)) begin
                    n_state = S_ED_DR;
                end
            end
            S_ED_DR: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pw    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pw    <= (r_state == S_CP) || (r_state == S_ED);
        end
    end

    // sweep counters and window
    always_ff @(posedge i_clk) begin
        r_pe  <= (r_state == S_ED);
        r_pwa <= r_i;
        if (r_state == S_IDLE && i_start) begin
            r_w         <= i_w;
            r_h         <= i_h;
            r_cells     <= i_cells;
            r_last_base <= AW'(i_cells - CW'(i_w));
            r_img       <= 1'b0;
            r_passes    <= i_cfg.fine_passes;
        end
        if (img_coarse) begin
            r_img    <= 1'b1;
            r_passes <= i_cfg.coarse_extra_passes;
        end
        if (pipe_init) begin
            r_i <= '0;
        end else if (r_state == S_CP || r_state == S_ED) begin
            r_i <= r_i + AW'(1);
        end

        if (r_state == S_BL_WR) begin
            r_win[r_slot] <= v;
            r_sum         <= sum_n;
            r_cnt         <= cnt_n;
            r_slot        <= (r_slot == SLW'(WINDOW - 1)) ? '0 : r_slot + SLW'(1);
            r_k           <= r_k + LW'(1);
            case (r_phase)
                2'd0:    r_addr <= r_addr + AW'(1);
                2'd1:    r_addr <= r_addr - AW'(1);
                2'd2:    r_addr <= r_addr + AW'(r_w);
                default: r_addr <= r_addr - AW'(r_w);
            endcase
        end

        if (line_end) begin
            for (int j = 0; j < WINDOW; j++) begin
                r_win[j] <= 8'd0;
            end
            r_sum  <= '0;
            r_cnt  <= '0;
            r_slot <= '0;
            r_k    <= '0;
            case (r_phase)
                2'd0: begin
                    r_phase <= 2'd1;
                    r_addr  <= r_row_base + AW'(r_w) - AW'(1);
                end
                2'd1: begin
                    if (r_line == LW'(r_h) - LW'(1)) begin
                        r_phase <= 2'd2;
                        r_line  <= '0;
                        r_addr  <= '0;
                    end else begin
                        r_phase    <= 2'd0;
                        r_line     <= r_line + LW'(1);
                        r_row_base <= r_row_base + AW'(r_w);
                        r_addr     <= r_row_base + AW'(r_w);
                    end
                end
                2'd2: begin
                    r_phase <= 2'd3;
                    r_addr  <= r_last_base + AW'(r_line);
                end
                default: begin
                    r_phase <= 2'd2;
                    r_line  <= r_line + LW'(1);
                    r_addr  <= AW'(r_line) + AW'(1);
                end
            endcase
        end

        if (blur_init || pass_next) begin
            r_pass     <= blur_init ? 3'd0 : r_pass + 3'd1;
            r_phase    <= 2'd0;
            r_line     <= '0;
            r_k        <= '0;
            r_addr     <= '0;
            r_row_base <= '0;
            for (int j = 0; j < WINDOW; j++) begin
                r_win[j] <= 8'd0;
            end
            r_sum  <= '0;
            r_cnt  <= '0;
            r_slot <= '0;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_ED_DR);

    assign o_f_we    = (r_state == S_BL_WR) && !r_img && (v != 8'd0);
    assign o_f_waddr = r_addr;
    assign o_f_wdata = prod[lbde_pkg::RECIP_SHIFT +: 8];
    assign o_f_raddr = (r_state == S_CP || r_state == S_ED) ? r_i : r_addr;

    assign o_c_we    = r_pw || ((r_state == S_BL_WR) && r_img && (v != 8'd0));
    assign o_c_waddr = r_pw ? r_pwa : r_addr;
    assign o_c_wdata = r_pw ? (r_pe ? lbde_pkg::edge_pix(i_f_rdata, i_c_rdata,
                                         i_cfg.edge_threshold, i_cfg.edge_value)
                                    : i_f_rdata)
                            : prod[lbde_pkg::RECIP_SHIFT +: 8];
    assign o_c_raddr = (r_state == S_ED) ? r_i : r_addr;

endmodule

### hdl/luma_blur_difference_edges.sv
// ----------------------------------------------------------------------------
// luma_blur_difference_edges
// Loads a luma frame, blurs it into fine and coarse images and reads out the
// thresholded difference as an edge map.
// ----------------------------------------------------------------------------
// Load beat: one per cycle while processing is idle. A read beat is first
// registered as pending with its store read, then lands in the output register.
// The last load beat starts processing, which holds ready low until it is done:
// each blur sweep pixel is read and then, if nonzero, written back on one store.
// Reset (synchronous, active low) restores registers, clears positions and
// the frame-ready flag; frame stores are not cleared.
module luma_blur_difference_edges #(
    parameter  int MAX_WIDTH  = lbde_pkg::LBDE_MAX_WIDTH,
    parameter  int MAX_HEIGHT = lbde_pkg::LBDE_MAX_HEIGHT,
    parameter  int WINDOW     = lbde_pkg::LBDE_WINDOW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lbde_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output lbde_pkg::t_out  o_out,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int WDW   = $clog2(MAX_WIDTH + 1);
    localparam int HDW   = $clog2(MAX_HEIGHT + 1);

    lbde_pkg::t_cfg r_cfg;

    // ---------------- configuration port ----------------
    logic       cfg_wr;
    logic [2:0] reg_idx;
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width         <= lbde_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height        <= lbde_pkg::RST_FRAME_HEIGHT;
            r_cfg.edge_threshold      <= lbde_pkg::RST_EDGE_THRESH;
            r_cfg.edge_value          <= lbde_pkg::RST_EDGE_VALUE;
            r_cfg.fine_passes         <= lbde_pkg::RST_FINE_PASSES;
            r_cfg.coarse_extra_passes <= lbde_pkg::RST_COARSE_EXTRA;
        end else if (cfg_wr) begin
            case (reg_idx)
                lbde_pkg::REG_FRAME_WIDTH:  r_cfg.frame_width         <= pwdata[7:0];
                lbde_pkg::REG_FRAME_HEIGHT: r_cfg.frame_height        <= pwdata[7:0];
                lbde_pkg::REG_EDGE_THRESH:  r_cfg.edge_threshold      <= pwdata[7:0];
                lbde_pkg::REG_EDGE_VALUE:   r_cfg.edge_value          <= pwdata[7:0];
                lbde_pkg::REG_FINE_PASSES:  r_cfg.fine_passes         <= pwdata[2:0];
                lbde_pkg::REG_COARSE_EXTRA: r_cfg.coarse_extra_passes <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lbde_pkg::REG_FRAME_WIDTH:  prdata = {24'd0, r_cfg.frame_width};
            lbde_pkg::REG_FRAME_HEIGHT: prdata = {24'd0, r_cfg.frame_height};
            lbde_pkg::REG_EDGE_THRESH:  prdata = {24'd0, r_cfg.edge_threshold};
            lbde_pkg::REG_EDGE_VALUE:   prdata = {24'd0, r_cfg.edge_value};
            lbde_pkg::REG_FINE_PASSES:  prdata = {29'd0, r_cfg.fine_passes};
            lbde_pkg::REG_COARSE_EXTRA: prdata = {29'd0, r_cfg.coarse_extra_passes};
            default:                    prdata = 32'd0;
        endcase
    end

    // ---------------- frame size: 0 counts as 1, large saturates ----------------
    logic [31:0]    fw32, fh32;
    logic [WDW-1:0] cur_w;
    logic [HDW-1:0] cur_h;
    logic [CW-1:0]  cur_cells;
    assign fw32 = {24'd0, r_cfg.frame_width};
    assign fh32 = {24'd0, r_cfg.frame_height};
    assign cur_w = (fw32 == 32'd0) ? WDW'(1) :
                   (fw32 > 32'(MAX_WIDTH)) ? WDW'(MAX_WIDTH) : WDW'(fw32);
    assign cur_h = (fh32 == 32'd0) ? HDW'(1) :
                   (fh32 > 32'(MAX_HEIGHT)) ? HDW'(MAX_HEIGHT) : HDW'(fh32);
    assign cur_cells = CW'(cur_w) * CW'(cur_h);

    // ---------------- input side ----------------
    logic          seq_busy, seq_done, seq_start;
    logic          in_acc, load_acc, read_acc;
    logic [CW-1:0] r_lp;          // next load position
    logic [CW-1:0] load_pos;
    logic [CW-1:0] r_cells;       // cells of the frame being read out
    logic          r_ready;       // an edge map exists
    logic [AW-1:0] r_rp;          // next readout position
    logic          r_pend, r_pend_last;

    // loads go whenever processing is idle; reads also need a free output slot
    assign o_in_ready = !seq_busy &&
                        ((i_in.command == lbde_pkg::CMD_LOAD) || (!r_pend && !o_out_valid));
    assign in_acc     = i_in_valid && o_in_ready;
    assign load_acc   = in_acc && (i_in.command == lbde_pkg::CMD_LOAD);
    assign read_acc   = in_acc && (i_in.command == lbde_pkg::CMD_READ);

    // partial frame is dropped if the frame shrank under it
    assign load_pos  = (r_lp >= cur_cells) ? '0 : r_lp;
    assign seq_start = load_acc && ((load_pos + CW'(1)) >= cur_cells);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp        <= '0;
            r_rp        <= '0;
            r_ready     <= 1'b0;
            r_cells     <= '0;
            r_pend      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (load_acc) begin
                r_lp <= seq_start ? '0 : load_pos + CW'(1);
            end
            if (seq_start) begin
                r_cells <= cur_cells;
            end
            if (seq_done) begin
                r_ready <= 1'b1;
                r_rp    <= '0;
            end
            r_pend <= read_acc && r_ready;
            if (read_acc && r_ready) begin
                r_pend_last <= (CW'(r_rp) == r_cells - CW'(1));
                r_rp        <= (CW'(r_rp) == r_cells - CW'(1)) ? '0 : r_rp + AW'(1);
            end
            if (r_pend) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- frame stores ----------------
    logic          f_we, c_we, sf_we, sc_we;
    logic [AW-1:0] f_waddr, f_raddr, c_waddr, c_raddr, sf_waddr, sf_raddr;
    logic [AW-1:0] sc_waddr, sc_raddr;
    logic [7:0]    f_wdata, c_wdata, f_rdata, c_rdata, sf_wdata, sc_wdata;

    assign f_we    = seq_busy ? sf_we    : load_acc;
    assign f_waddr = seq_busy ? sf_waddr : AW'(load_pos);
    assign f_wdata = seq_busy ? sf_wdata : i_in.pixel;
    assign f_raddr = sf_raddr;
    assign c_we    = sc_we;
    assign c_waddr = sc_waddr;
    assign c_wdata = sc_wdata;
    assign c_raddr = seq_busy ? sc_raddr : r_rp;

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            o_out.edge_res      <= c_rdata;
            o_out.last_of_frame <= r_pend_last;
        end
    end

    lbde_ram #(.DEPTH(CELLS)) u_fine (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    lbde_ram #(.DEPTH(CELLS)) u_coarse (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    lbde_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WINDOW     (WINDOW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (seq_start),
        .i_w       (cur_w),
        .i_h       (cur_h),
        .i_cells   (cur_cells),
        .i_cfg     (r_cfg),
        .o_busy    (seq_busy),
        .o_done    (seq_done),
        .o_f_we    (sf_we),
        .o_f_waddr (sf_waddr),
        .o_f_wdata (sf_wdata),
        .o_f_raddr (sf_raddr),
        .i_f_rdata (f_rdata),
        .o_c_we    (sc_we),
        .o_c_waddr (sc_waddr),
        .o_c_wdata (sc_wdata),
        .o_c_raddr (sc_raddr),
        .i_c_rdata (c_rdata)
    );

endmodule

### hdl/lbde_checker.sv
// ----------------------------------------------------------------------------
// lbde_checker
// Port-level checks for the edge block, bound to the top level.
// ----------------------------------------------------------------------------
module lbde_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input lbde_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input lbde_pkg::t_out o_out,
    input logic           pready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output beat changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    a_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && o_in_ready && (i_in.command == lbde_pkg::CMD_READ), 2))
        else $error("result without a read beat");

endmodule

bind luma_blur_difference_edges lbde_checker u_lbde_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .pready      (pready)
);

### sim/lbde_edge_checker.sv
// ----------------------------------------------------------------------------
// lbde_edge_checker
// Watches the pixel and edge channels and the register port, predicts each
// edge map beat with its own difference-of-blurs model and compares it.
// ----------------------------------------------------------------------------
module lbde_edge_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  lbde_pkg::t_in   i_in,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  lbde_pkg::t_out  i_out,
    input  logic            i_psel,
    input  logic            i_penable,
    input  logic            i_pwrite,
    input  logic [4:0]      i_paddr,
    input  logic [31:0]     i_pwdata,
    input  logic            i_pready,
    output int              o_fail_count,
    output int              o_pending
);

    localparam int CELLS = lbde_pkg::LBDE_MAX_WIDTH * lbde_pkg::LBDE_MAX_HEIGHT;

    lbde_pkg::t_cfg cfg;
    logic [7:0]     fine_img [CELLS];
    logic [7:0]     edge_img [CELLS];
    logic [7:0]     work_img [CELLS];
    int             load_pos, read_pos, map_cells;
    bit             map_ready;
    lbde_pkg::t_out edge_fifo [$];

    assign o_pending = edge_fifo.size();

    function automatic int clamp_dim(input logic [7:0] v, input int maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : int'(v);
    endfunction

    task automatic line_avg(input int start, input int step, input int len);
        logic [7:0] win [lbde_pkg::LBDE_WINDOW];
        int sum, cnt, slot, idx;
        logic [7:0] v, old;
        sum = 0; cnt = 0; slot = 0; idx = start;
        foreach (win[i]) win[i] = 8'd0;
        for (int k = 0; k < len; k++) begin
            v = work_img[idx];
            old = win[slot];
            win[slot] = v;
            if (old != 0) begin
                sum -= old; cnt--;
            end
            if (v != 0) begin
                sum += v; cnt++;
                work_img[idx] = 8'(sum / cnt);
            end
            slot = (slot + 1) % lbde_pkg::LBDE_WINDOW;
            idx += step;
        end
    endtask

    task automatic blur_work(input int w, input int h, input int passes);
        for (int p = 0; p < passes; p++) begin
            for (int y = 0; y < h; y++) begin
                line_avg(y * w, 1, w);
                line_avg(y * w + w - 1, -1, w);
            end
            for (int x = 0; x < w; x++) begin
                line_avg(x, w, h);
                line_avg((h - 1) * w + x, -w, h);
            end
        end
    endtask

    task automatic build_edge_map(input int w, input int h);
        int n;
        logic [7:0] a, b, d;
        n = w * h;
        for (int i = 0; i < n; i++) work_img[i] = fine_img[i];
        blur_work(w, h, cfg.fine_passes);
        for (int i = 0; i < n; i++) fine_img[i] = work_img[i];
        blur_work(w, h, cfg.coarse_extra_passes);
        for (int i = 0; i < n; i++) begin
            a = fine_img[i]; b = work_img[i];
            d = (a > b) ? a - b : b - a;
            edge_img[i] = (d > cfg.edge_threshold) ? cfg.edge_value : 8'd0;
        end
        map_cells = n;
        map_ready = 1'b1;
        read_pos = 0;
    endtask

    task automatic take_beat(input lbde_pkg::t_in beat);
        int w, h, n;
        lbde_pkg::t_out exp_beat;
        if (beat.command == lbde_pkg::CMD_LOAD) begin
            w = clamp_dim(cfg.frame_width, lbde_pkg::LBDE_MAX_WIDTH);
            h = clamp_dim(cfg.frame_height, lbde_pkg::LBDE_MAX_HEIGHT);
            n = w * h;
            if (load_pos >= n) load_pos = 0;
            fine_img[load_pos] = beat.pixel;
            load_pos++;
            if (load_pos >= n) begin
                load_pos = 0;
                build_edge_map(w, h);
            end
        end else if (map_ready) begin
            if (read_pos >= map_cells) read_pos = 0;
            exp_beat.edge_res = edge_img[read_pos];
            exp_beat.last_of_frame = (read_pos == map_cells - 1);
            edge_fifo.push_back(exp_beat);
            read_pos++;
            if (read_pos >= map_cells) read_pos = 0;
        end
    endtask

    always @(posedge i_clk) begin
        lbde_pkg::t_out want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            cfg = '{lbde_pkg::RST_FRAME_WIDTH, lbde_pkg::RST_FRAME_HEIGHT,
                    lbde_pkg::RST_EDGE_THRESH, lbde_pkg::RST_EDGE_VALUE,
                    lbde_pkg::RST_FINE_PASSES, lbde_pkg::RST_COARSE_EXTRA};
            load_pos = 0;
            read_pos = 0;
            map_ready = 1'b0;
            map_cells = 0;
            o_fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    lbde_pkg::REG_FRAME_WIDTH:  cfg.frame_width = i_pwdata[7:0];
                    lbde_pkg::REG_FRAME_HEIGHT: cfg.frame_height = i_pwdata[7:0];
                    lbde_pkg::REG_EDGE_THRESH:  cfg.edge_threshold = i_pwdata[7:0];
                    lbde_pkg::REG_EDGE_VALUE:   cfg.edge_value = i_pwdata[7:0];
                    lbde_pkg::REG_FINE_PASSES:  cfg.fine_passes = i_pwdata[2:0];
                    lbde_pkg::REG_COARSE_EXTRA: cfg.coarse_extra_passes = i_pwdata[2:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (edge_fifo.size() == 0) begin
                    $error("unexpected edge beat %h", i_out);
                    errs++;
                end else begin
                    want = edge_fifo.pop_front();
                    if (want.edge_res !== i_out.edge_res) begin
                        $error("edge_res exp %0d got %0d", want.edge_res, i_out.edge_res);
                        errs++;
                    end
                    if (want.last_of_frame !== i_out.last_of_frame) begin
                        $error("last_of_frame exp %0d got %0d",
                               want.last_of_frame, i_out.last_of_frame);
                        errs++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) take_beat(i_in);
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

### sim/tb_luma_blur_difference_edges.sv
// ----------------------------------------------------------------------------
// tb_luma_blur_difference_edges
// Stimulus for the edge block: small frames loaded and read back under
// several register settings and handshake idling patterns; the checker
// predicts and compares every edge beat.
// ----------------------------------------------------------------------------
module tb_luma_blur_difference_edges;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    lbde_pkg::t_in  in_beat = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    lbde_pkg::t_out out_beat;
    logic           psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;
    int             fail_count, pending;
    int             send_idle_pct = 0;   // chance of a gap before a beat
    int             recv_stall_pct = 0;  // chance the receiver holds ready low
    bit             recv_hold = 1'b0;    // long receiver hold-off in progress
    int             cycles = 0;
    int             cur_w = 128, cur_h = 128;

    always #5 i_clk = ~i_clk;

    luma_blur_difference_edges dut (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_beat),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_beat),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    lbde_edge_checker chk (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in(in_beat),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out(out_beat),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, or held low during a hold-off
    always @(posedge i_clk) begin
        out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // register write: setup then access beat
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == lbde_pkg::REG_FRAME_WIDTH)
            cur_w = (val == 0) ? 1 : (val > 128 ? 128 : val);
        if (idx == lbde_pkg::REG_FRAME_HEIGHT)
            cur_h = (val == 0) ? 1 : (val > 128 ? 128 : val);
    endtask

    // one beat on the pixel channel; valid stays up across back-to-back beats
    task automatic send_beat(input logic cmd, input logic [7:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat <= '{cmd, pix};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every expected edge beat, then for frame processing to finish
    task automatic drain();
        go_idle();
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    // load a full frame then send the given number of read beats, fewer or more than it holds
    task automatic frame_round(input int reads);
        for (int i = 0; i < cur_w * cur_h; i++) send_beat(lbde_pkg::CMD_LOAD, rand_pixel());
        for (int i = 0; i < reads; i++) send_beat(lbde_pkg::CMD_READ, 8'($urandom));
    endtask

    task automatic set_cfg(input int w, input int h, input int thr, input int val,
                           input int fp, input int cp);
        write_reg(lbde_pkg::REG_FRAME_WIDTH, 8'(w));
        write_reg(lbde_pkg::REG_FRAME_HEIGHT, 8'(h));
        write_reg(lbde_pkg::REG_EDGE_THRESH, 8'(thr));
        write_reg(lbde_pkg::REG_EDGE_VALUE, 8'(val));
        write_reg(lbde_pkg::REG_FINE_PASSES, 8'(fp));
        write_reg(lbde_pkg::REG_COARSE_EXTRA, 8'(cp));
    endtask

    int sent;

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: read before any frame, tiny frames, zero passes, wrap
        send_beat(lbde_pkg::CMD_READ, 8'hFF);
        drain();
        set_cfg(3, 2, 0, 255, 0, 7);
        send_beat(lbde_pkg::CMD_LOAD, 8'd0);
        send_beat(lbde_pkg::CMD_LOAD, 8'd255);
        send_beat(lbde_pkg::CMD_LOAD, 8'd1);
        send_beat(lbde_pkg::CMD_LOAD, 8'd128);
        send_beat(lbde_pkg::CMD_LOAD, 8'd0);
        send_beat(lbde_pkg::CMD_LOAD, 8'd77);
        for (int i = 0; i < 8; i++) send_beat(lbde_pkg::CMD_READ, 8'd0);   // wraps
        drain();
        // zero sizes count as one, oversize saturates (height kept small)
        set_cfg(0, 0, 255, 1, 7, 0);
        send_beat(lbde_pkg::CMD_LOAD, 8'd200);
        send_beat(lbde_pkg::CMD_READ, 8'd0);
        drain();
        set_cfg(255, 1, 5, 240, 1, 2);
        frame_round(4);
        drain();
        // frame shrunk during a load: partial frame dropped
        set_cfg(4, 2, 3, 100, 2, 1);
        for (int i = 0; i < 6; i++) send_beat(lbde_pkg::CMD_LOAD, rand_pixel());
        drain();
        write_reg(lbde_pkg::REG_FRAME_WIDTH, 8'd2);
        frame_round(5);
        drain();

        // random phases over idling patterns
        sent = 0;
        for (int ph = 0; sent < 360; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            set_cfg($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(0, 40),
                    8'($urandom), $urandom_range(0, 3), $urandom_range(0, 3));
            if (ph % 5 == 2) write_reg(lbde_pkg::REG_EDGE_THRESH, 8'd255);
            for (int f = 0; f < 3; f++) begin
                int reads;
                reads = $urandom_range(0, cur_w * cur_h + 3);
                frame_round(reads);
                sent += cur_w * cur_h + reads;
                // load during readout, then a stray read
                if ($urandom_range(3) == 0) begin
                    send_beat(lbde_pkg::CMD_LOAD, rand_pixel());
                    send_beat(lbde_pkg::CMD_READ, 8'd0);
                    sent += 2;
                end
            end
            if (ph == 2) begin
                // long receiver hold-off while reads keep coming
                recv_hold = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge i_clk);
                        recv_hold = 1'b0;
                    end
                    for (int i = 0; i < 40; i++) send_beat(lbde_pkg::CMD_READ, 8'd0);
                join
                sent += 40;
            end
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
